// ----- rtl/core/avt_pkg.sv -----
// ----------------------------------------------------------------------------
// avt_pkg
// Types and constants shared by the affine vector transform pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package avt_pkg;

  localparam int VEC_W      = 32;
  localparam int ENT_W      = 16;
  localparam int ROW_W      = 3 * ENT_W;
  localparam int FRAC_SHIFT = 14;
  localparam int DIFF_W     = VEC_W + 1;
  localparam int PROD_W     = DIFF_W + ENT_W;
  localparam int BIAS_W     = VEC_W + FRAC_SHIFT;
  localparam int ACC_W      = PROD_W + 3;
  localparam int SHR_W      = ACC_W - FRAC_SHIFT;
  localparam int IDX_W      = 3;

  typedef enum logic [1:0] {
    OP_XFORM      = 2'd0,
    OP_ROTATE     = 2'd1,
    OP_INV_ROTATE = 2'd2,
    OP_INV_XFORM  = 2'd3
  } avt_op_t;

  localparam logic [IDX_W-1:0] REG_ROT_ROW0 = 3'd0;
  localparam logic [IDX_W-1:0] REG_ROT_ROW1 = 3'd1;
  localparam logic [IDX_W-1:0] REG_ROT_ROW2 = 3'd2;
  localparam logic [IDX_W-1:0] REG_TRANS_X  = 3'd3;
  localparam logic [IDX_W-1:0] REG_TRANS_Y  = 3'd4;
  localparam logic [IDX_W-1:0] REG_TRANS_Z  = 3'd5;

  localparam logic [ROW_W-1:0] ROT_ROW0_RST = 48'h0000_0000_4000;
  localparam logic [ROW_W-1:0] ROT_ROW1_RST = 48'h0000_4000_0000;
  localparam logic [ROW_W-1:0] ROT_ROW2_RST = 48'h4000_0000_0000;

  typedef logic signed [VEC_W-1:0]  avt_vec_t;
  typedef logic signed [DIFF_W-1:0] avt_diff_t;
  typedef logic signed [ENT_W-1:0]  avt_ent_t;
  typedef logic signed [PROD_W-1:0] avt_prod_t;
  typedef logic signed [BIAS_W-1:0] avt_bias_t;
  typedef logic signed [ACC_W-1:0]  avt_acc_t;
  typedef logic signed [SHR_W-1:0]  avt_shr_t;

  typedef struct packed {
    avt_op_t  operation;
    avt_vec_t vec_x;
    avt_vec_t vec_y;
    avt_vec_t vec_z;
  } avt_in_t;

  typedef struct packed {
    avt_vec_t out_x;
    avt_vec_t out_y;
    avt_vec_t out_z;
    logic     saturated;
  } avt_out_t;

  typedef struct packed {
    logic [2:0][ROW_W-1:0] rot_row;
    avt_vec_t [2:0]        trans;
  } avt_cfg_t;

  typedef struct packed {
    avt_diff_t [2:0]      vec;
    avt_ent_t  [2:0][2:0] mat;
    avt_bias_t [2:0]      bias;
  } avt_prep_t;

  typedef struct packed {
    avt_prod_t [2:0][2:0] prod;
    avt_bias_t [2:0]      bias;
  } avt_mult_t;

  typedef struct packed {
    avt_acc_t [2:0] acc;
  } avt_sum_t;

endpackage

`default_nettype wire

// ----- rtl/core/avt_prep.sv -----
// ----------------------------------------------------------------------------
// avt_prep
// Operand stage: translation subtract, matrix or transpose select, bias.
// ----------------------------------------------------------------------------
`default_nettype none

module avt_prep (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire avt_pkg::avt_cfg_t cfg,
  input  wire logic              up_valid,
  output logic                   up_stall,
  input  wire avt_pkg::avt_in_t  up_data,
  output logic                   dn_valid,
  input  wire logic              dn_stall,
  output avt_pkg::avt_prep_t     dn_data
);

  logic               vld_r;
  logic               vld_nxt;
  logic               load;
  avt_pkg::avt_prep_t data_r;
  avt_pkg::avt_prep_t data_nxt;
  avt_pkg::avt_vec_t  vin [3];

  assign load     = !vld_r || !dn_stall;
  assign up_stall = !load;
  assign vld_nxt  = load ? up_valid : vld_r;
  assign vin[0]   = up_data.vec_x;
  assign vin[1]   = up_data.vec_y;
  assign vin[2]   = up_data.vec_z;

  always_comb begin
    data_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      data_nxt.vec[i] = avt_pkg::avt_diff_t'(vin[i]);
      if (up_data.operation == avt_pkg::OP_INV_XFORM) begin
        data_nxt.vec[i] = avt_pkg::avt_diff_t'(vin[i]) - avt_pkg::avt_diff_t'(cfg.trans[i]);
      end
      if (up_data.operation == avt_pkg::OP_XFORM) begin
        data_nxt.bias[i] = {cfg.trans[i], {avt_pkg::FRAC_SHIFT{1'b0}}};
      end
      for (int j = 0; j < 3; j++) begin
        if (up_data.operation == avt_pkg::OP_INV_ROTATE ||
            up_data.operation == avt_pkg::OP_INV_XFORM) begin
          data_nxt.mat[i][j] = cfg.rot_row[j][avt_pkg::ENT_W*i +: avt_pkg::ENT_W];
        end else begin
          data_nxt.mat[i][j] = cfg.rot_row[i][avt_pkg::ENT_W*j +: avt_pkg::ENT_W];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (load) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

// ----- rtl/core/avt_mult.sv -----
// ----------------------------------------------------------------------------
// avt_mult
// Product stage: nine 33x16 signed products.
// ----------------------------------------------------------------------------
`default_nettype none

module avt_mult (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               up_valid,
  output logic                    up_stall,
  input  wire avt_pkg::avt_prep_t up_data,
  output logic                    dn_valid,
  input  wire logic               dn_stall,
  output avt_pkg::avt_mult_t      dn_data
);

  logic               vld_r;
  logic               vld_nxt;
  logic               load;
  avt_pkg::avt_mult_t data_r;
  avt_pkg::avt_mult_t data_nxt;

  assign load     = !vld_r || !dn_stall;
  assign up_stall = !load;
  assign vld_nxt  = load ? up_valid : vld_r;

  always_comb begin
    data_nxt.bias = up_data.bias;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        data_nxt.prod[i][j] = avt_pkg::avt_prod_t'(up_data.vec[j]) *
                              avt_pkg::avt_prod_t'(up_data.mat[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (load) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

// ----- rtl/core/avt_accum.sv -----
// ----------------------------------------------------------------------------
// avt_accum
// Sum stage: row products plus translation bias, full precision.
// ----------------------------------------------------------------------------
`default_nettype none

module avt_accum (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               up_valid,
  output logic                    up_stall,
  input  wire avt_pkg::avt_mult_t up_data,
  output logic                    dn_valid,
  input  wire logic               dn_stall,
  output avt_pkg::avt_sum_t       dn_data
);

  logic              vld_r;
  logic              vld_nxt;
  logic              load;
  avt_pkg::avt_sum_t data_r;
  avt_pkg::avt_sum_t data_nxt;

  assign load     = !vld_r || !dn_stall;
  assign up_stall = !load;
  assign vld_nxt  = load ? up_valid : vld_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      data_nxt.acc[i] = avt_pkg::avt_acc_t'(up_data.prod[i][0]) +
                        avt_pkg::avt_acc_t'(up_data.prod[i][1]) +
                        avt_pkg::avt_acc_t'(up_data.prod[i][2]) +
                        avt_pkg::avt_acc_t'(up_data.bias[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (load) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

// ----- rtl/core/avt_clip.sv -----
// ----------------------------------------------------------------------------
// avt_clip
// Result stage: floor rounding to Q16.16 and 32-bit saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module avt_clip (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              up_valid,
  output logic                   up_stall,
  input  wire avt_pkg::avt_sum_t up_data,
  output logic                   dn_valid,
  input  wire logic              dn_stall,
  output avt_pkg::avt_out_t      dn_data
);

  logic              vld_r;
  logic              vld_nxt;
  logic              load;
  avt_pkg::avt_out_t data_r;
  avt_pkg::avt_out_t data_nxt;
  avt_pkg::avt_shr_t shr [3];
  avt_pkg::avt_vec_t res [3];
  logic [2:0]        clip;

  assign load     = !vld_r || !dn_stall;
  assign up_stall = !load;
  assign vld_nxt  = load ? up_valid : vld_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // arithmetic shift is floor rounding
      shr[i]  = avt_pkg::avt_shr_t'(up_data.acc[i] >>> avt_pkg::FRAC_SHIFT);
      clip[i] = !((&shr[i][avt_pkg::SHR_W-1:avt_pkg::VEC_W-1]) ||
                  !(|shr[i][avt_pkg::SHR_W-1:avt_pkg::VEC_W-1]));
      if (!clip[i]) begin
        res[i] = shr[i][avt_pkg::VEC_W-1:0];
      end else if (shr[i][avt_pkg::SHR_W-1]) begin
        res[i] = {1'b1, {(avt_pkg::VEC_W-1){1'b0}}};
      end else begin
        res[i] = {1'b0, {(avt_pkg::VEC_W-1){1'b1}}};
      end
    end
    data_nxt.out_x     = res[0];
    data_nxt.out_y     = res[1];
    data_nxt.out_z     = res[2];
    data_nxt.saturated = |clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (load) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

// ----- rtl/core/affine_vector_transform_top.sv -----
// ----------------------------------------------------------------------------
// affine_vector_transform_top
// 3x4 affine transform of Q16.16 vectors: rotate, translate and inverses.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_stall   avt_in_t
//  out_     output     out_valid / out_stall avt_out_t
//  cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
//  four register stages: operand select, products, sum, round and clip
//  one item per cycle when out_stall is low; results leave in the order items are accepted
//  an output stall backs up stage by stage; empty stages still fill
//  synchronous reset loads the identity matrix and zero translation
// ----------------------------------------------------------------------------
`default_nettype none

module affine_vector_transform_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire avt_pkg::avt_in_t              in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output avt_pkg::avt_out_t                  out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [avt_pkg::IDX_W-1:0]     cfg_index,
  input  wire logic [avt_pkg::ROW_W-1:0]     cfg_data
);

  avt_pkg::avt_cfg_t  cfg_r;
  avt_pkg::avt_prep_t prep_data;
  avt_pkg::avt_mult_t mult_data;
  avt_pkg::avt_sum_t  sum_data;
  logic               prep_valid;
  logic               prep_stall;
  logic               mult_valid;
  logic               mult_stall;
  logic               sum_valid;
  logic               sum_stall;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rot_row[0] <= avt_pkg::ROT_ROW0_RST;
      cfg_r.rot_row[1] <= avt_pkg::ROT_ROW1_RST;
      cfg_r.rot_row[2] <= avt_pkg::ROT_ROW2_RST;
      cfg_r.trans      <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        avt_pkg::REG_ROT_ROW0: cfg_r.rot_row[0] <= cfg_data;
        avt_pkg::REG_ROT_ROW1: cfg_r.rot_row[1] <= cfg_data;
        avt_pkg::REG_ROT_ROW2: cfg_r.rot_row[2] <= cfg_data;
        avt_pkg::REG_TRANS_X:  cfg_r.trans[0]   <= cfg_data[avt_pkg::VEC_W-1:0];
        avt_pkg::REG_TRANS_Y:  cfg_r.trans[1]   <= cfg_data[avt_pkg::VEC_W-1:0];
        avt_pkg::REG_TRANS_Z:  cfg_r.trans[2]   <= cfg_data[avt_pkg::VEC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  avt_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .up_data  (in_data),
    .dn_valid (prep_valid),
    .dn_stall (prep_stall),
    .dn_data  (prep_data)
  );

  avt_mult u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (prep_valid),
    .up_stall (prep_stall),
    .up_data  (prep_data),
    .dn_valid (mult_valid),
    .dn_stall (mult_stall),
    .dn_data  (mult_data)
  );

  avt_accum u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mult_valid),
    .up_stall (mult_stall),
    .up_data  (mult_data),
    .dn_valid (sum_valid),
    .dn_stall (sum_stall),
    .dn_data  (sum_data)
  );

  avt_clip u_clip (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (sum_valid),
    .up_stall (sum_stall),
    .up_data  (sum_data),
    .dn_valid (out_valid),
    .dn_stall (out_stall),
    .dn_data  (out_data)
  );

endmodule

`default_nettype wire
